// ----- src/clipped_pixel_raster_engine_unit_macros.svh -----
// Assertion helpers used by the raster engine queue.
`ifndef CLIPPED_PIXEL_RASTER_ENGINE_UNIT_MACROS_SVH
`define CLIPPED_PIXEL_RASTER_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge out of reset
`define CPRE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("cpre assertion failed");
// cond must never be seen at a clock edge out of reset
`define CPRE_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("cpre forbidden condition");
`else
`define CPRE_ASSERT(lbl, clk, rst_n, prop)
`define CPRE_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- src/cpre_pkg.sv -----
package cpre_pkg;

	localparam int SCR_BITS = 11;
	localparam int ADDR_BITS = 20;
	localparam int COLOR_BITS = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = 2;
	localparam int CLEAR_CAP = 1 << ADDR_BITS;

	localparam logic [2:0] OP_TICK = 3'd0;
	localparam logic [2:0] OP_CLEAR = 3'd1;
	localparam logic [2:0] OP_PLOT = 3'd2;
	localparam logic [2:0] OP_LINE = 3'd3;
	localparam logic [2:0] OP_RECT = 3'd4;
	localparam logic [2:0] OP_FILL = 3'd5;

	localparam logic CFG_WIDTH = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef enum logic [5:0] {
		MODE_IDLE  = 6'b000001,
		MODE_CLEAR = 6'b000010,
		MODE_PLOT  = 6'b000100,
		MODE_LINE  = 6'b001000,
		MODE_RECT  = 6'b010000,
		MODE_FILL  = 6'b100000
	} mode_t;

	// one result beat on its way from the front to the back
	typedef struct packed {
		logic                  we;
		logic                  mul;
		logic [ADDR_BITS-1:0]  caddr;
		logic [SCR_BITS-1:0]   px;
		logic [SCR_BITS-1:0]   py;
		logic [SCR_BITS-1:0]   stride;
		logic [COLOR_BITS-1:0] color;
		logic                  last;
		logic                  busy;
	} pix_rec_t;

	// screen geometry after saturation
	typedef struct packed {
		logic [SCR_BITS-1:0] w;
		logic [SCR_BITS-1:0] h;
		logic [ADDR_BITS:0]  clen;
	} geom_t;

endpackage

// ----- src/cpre_front.sv -----
module cpre_front #(
	parameter int COORD_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  op,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] to_x,
	input  logic signed [COORD_BITS-1:0] to_y,
	input  logic signed [COORD_BITS-1:0] rect_width,
	input  logic signed [COORD_BITS-1:0] rect_height,
	input  logic [cpre_pkg::COLOR_BITS-1:0] color,
	input  cpre_pkg::geom_t             geom,
	output logic                        push,
	output cpre_pkg::pix_rec_t          rec,
	input  logic                        full
);
	import cpre_pkg::*;

	localparam int PW = (COORD_BITS + 2 > SCR_BITS + 1) ? COORD_BITS + 2 : SCR_BITS + 1;
	localparam int DW = COORD_BITS + 1;
	localparam int EW = COORD_BITS + 3;

	mode_t mode_q, mode_d;
	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, end_x_q, end_y_q;
	logic signed [COORD_BITS-1:0] cur_x_d, cur_y_d, end_x_d, end_y_d;
	logic [DW-1:0] dx_q, dy_q, dx_d, dy_d;
	logic sxn_q, syn_q, sxn_d, syn_d;
	logic signed [EW-1:0] err_q, err_d;
	logic [COLOR_BITS-1:0] pen_q, pen_d;
	logic signed [COORD_BITS-1:0] bx_q, by_q, bw_q, bh_q, bx_d, by_d, bw_d, bh_d;
	logic signed [PW-1:0] outer_q, outer_d;
	logic inner_q, inner_d;
	logic signed [PW-1:0] fin_q, fin_d;
	logic phase_q, phase_d;
	logic [ADDR_BITS-1:0] ccnt_q, ccnt_d;

	logic signed [PW-1:0] pix_x, pix_y, bxe, bye, bwe, bhe;
	logic pix_en, pix_last, in_scr;
	logic signed [DW-1:0] xs, ys, exs, eys;
	logic signed [EW-1:0] e2, dxe, dye;
	logic cmd;

	assign in_ready = !full;
	assign push = in_valid && in_ready;
	assign cmd = (op == OP_CLEAR) || (op == OP_PLOT) || (op == OP_LINE)
		|| (op == OP_RECT) || (op == OP_FILL);

	assign bxe = PW'(bx_q);
	assign bye = PW'(by_q);
	assign bwe = PW'(bw_q);
	assign bhe = PW'(bh_q);
	assign xs = DW'(pos_x);
	assign ys = DW'(pos_y);
	assign exs = DW'(to_x);
	assign eys = DW'(to_y);
	assign e2 = err_q <<< 1;
	assign dxe = $signed({2'b00, dx_q});
	assign dye = $signed({2'b00, dy_q});

	always_comb begin
		mode_d = mode_q;
		cur_x_d = cur_x_q; cur_y_d = cur_y_q; end_x_d = end_x_q; end_y_d = end_y_q;
		dx_d = dx_q; dy_d = dy_q; sxn_d = sxn_q; syn_d = syn_q; err_d = err_q;
		pen_d = pen_q; bx_d = bx_q; by_d = by_q; bw_d = bw_q; bh_d = bh_q;
		outer_d = outer_q; inner_d = inner_q; phase_d = phase_q; ccnt_d = ccnt_q;
		fin_d = fin_q;
		pix_x = '0; pix_y = '0; pix_en = 1'b0; pix_last = 1'b0;
		in_scr = 1'b0;
		rec = '0;
		if (cmd) begin
			pen_d = color;
			cur_x_d = pos_x;
			cur_y_d = pos_y;
			case (op)
				OP_CLEAR: begin
					mode_d = (geom.clen == '0) ? MODE_IDLE : MODE_CLEAR;
					ccnt_d = '0;
				end
				OP_PLOT: mode_d = MODE_PLOT;
				OP_LINE: begin
					mode_d = MODE_LINE;
					end_x_d = to_x;
					end_y_d = to_y;
					dx_d = (exs > xs) ? DW'(exs - xs) : DW'(xs - exs);
					dy_d = (eys > ys) ? DW'(eys - ys) : DW'(ys - eys);
					sxn_d = !(xs < exs);
					syn_d = !(ys < eys);
					err_d = $signed({2'b00, dx_d}) - $signed({2'b00, dy_d});
				end
				default: begin
					mode_d = (op == OP_RECT) ? MODE_RECT : MODE_FILL;
					bx_d = pos_x; by_d = pos_y; bw_d = rect_width; bh_d = rect_height;
					outer_d = '0; inner_d = 1'b0; phase_d = 1'b0;
					if (rect_width <= 0 || rect_height <= 0)
						mode_d = MODE_IDLE;
				end
			endcase
			rec.busy = (mode_d != MODE_IDLE);
		end else begin
			case (mode_q)
				MODE_CLEAR: begin
					rec.we = 1'b1;
					rec.caddr = ccnt_q;
					rec.color = pen_q;
					rec.last = ({1'b0, ccnt_q} + 1'b1) >= geom.clen;
					rec.busy = !rec.last;
					ccnt_d = ccnt_q + 1'b1;
					if (rec.last)
						mode_d = MODE_IDLE;
				end
				MODE_PLOT: begin
					pix_en = 1'b1; pix_last = 1'b1;
					pix_x = PW'(cur_x_q); pix_y = PW'(cur_y_q);
				end
				MODE_LINE: begin
					pix_en = 1'b1;
					pix_x = PW'(cur_x_q); pix_y = PW'(cur_y_q);
					pix_last = (cur_x_q == end_x_q) && (cur_y_q == end_y_q);
					if (!pix_last) begin
						if (e2 > -dye) begin
							err_d = err_d - dye;
							cur_x_d = sxn_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
						end
						if (e2 < dxe) begin
							err_d = err_d + dxe;
							cur_y_d = syn_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
						end
					end
				end
				MODE_RECT: begin
					pix_en = 1'b1;
					if (!phase_q) begin
						pix_x = bxe + outer_q;
						pix_y = inner_q ? bye + bhe - 1'b1 : bye;
						inner_d = !inner_q;
						if (inner_q) begin
							outer_d = outer_q + 1'b1;
							if (outer_d >= bwe) begin
								outer_d = '0;
								phase_d = 1'b1;
							end
						end
					end else begin
						pix_x = inner_q ? bxe + bwe - 1'b1 : bxe;
						pix_y = bye + outer_q;
						inner_d = !inner_q;
						if (inner_q) begin
							pix_last = outer_q >= bhe - 1'b1;
							outer_d = outer_q + 1'b1;
						end
					end
				end
				MODE_FILL: begin
					pix_en = 1'b1;
					pix_x = bxe + outer_q;
					pix_y = bye + fin_q;
					pix_last = (outer_q >= bwe - 1'b1) && (fin_q >= bhe - 1'b1);
					fin_d = fin_q + 1'b1;
					if (fin_d >= bhe) begin
						fin_d = '0;
						outer_d = outer_q + 1'b1;
					end
				end
				default: mode_d = MODE_IDLE;
			endcase
			if (pix_en) begin
				in_scr = !pix_x[PW-1] && !pix_y[PW-1]
					&& (pix_x < $signed({{(PW-SCR_BITS){1'b0}}, geom.w}))
					&& (pix_y < $signed({{(PW-SCR_BITS){1'b0}}, geom.h}));
				rec.we = in_scr;
				rec.mul = in_scr;
				rec.px = in_scr ? pix_x[SCR_BITS-1:0] : '0;
				rec.py = in_scr ? pix_y[SCR_BITS-1:0] : '0;
				// stride travels with the beat so a later width write cannot touch it
				rec.stride = geom.w;
				rec.color = in_scr ? pen_q : '0;
				rec.last = pix_last;
				rec.busy = !pix_last;
				if (pix_last)
					mode_d = MODE_IDLE;
			end else begin
				in_scr = 1'b0;
			end
		end
		if (mode_d != MODE_FILL && cmd)
			fin_d = '0;
		if (cmd)
			fin_d = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			cur_x_q <= '0; cur_y_q <= '0; end_x_q <= '0; end_y_q <= '0;
			dx_q <= '0; dy_q <= '0; sxn_q <= 1'b0; syn_q <= 1'b0; err_q <= '0;
			pen_q <= '0; bx_q <= '0; by_q <= '0; bw_q <= '0; bh_q <= '0;
			outer_q <= '0; inner_q <= 1'b0; fin_q <= '0; phase_q <= 1'b0;
			ccnt_q <= '0;
		end else if (push) begin
			mode_q <= mode_d;
			cur_x_q <= cur_x_d; cur_y_q <= cur_y_d; end_x_q <= end_x_d; end_y_q <= end_y_d;
			dx_q <= dx_d; dy_q <= dy_d; sxn_q <= sxn_d; syn_q <= syn_d; err_q <= err_d;
			pen_q <= pen_d; bx_q <= bx_d; by_q <= by_d; bw_q <= bw_d; bh_q <= bh_d;
			outer_q <= outer_d; inner_q <= inner_d; fin_q <= fin_d; phase_q <= phase_d;
			ccnt_q <= ccnt_d;
		end
	end

endmodule

// ----- src/cpre_queue.sv -----
`include "clipped_pixel_raster_engine_unit_macros.svh"

module cpre_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cpre_pkg::pix_rec_t wr_rec,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output cpre_pkg::pix_rec_t rd_rec
);
	import cpre_pkg::*;

	pix_rec_t mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wptr_q, rptr_q;
	logic [QPTR_BITS:0] cnt_q;

	assign full = (cnt_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_rec = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
		end
	end

	`CPRE_NEVER(a_no_overflow, clk, arst_n, push && full && !pop)
	`CPRE_NEVER(a_no_underflow, clk, arst_n, pop && !not_empty)
	`CPRE_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= (QPTR_BITS+1)'(QUEUE_DEPTH))

endmodule

// ----- src/cpre_back.sv -----
module cpre_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	input  cpre_pkg::pix_rec_t              head,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            write_enable,
	output logic [cpre_pkg::ADDR_BITS-1:0]  pixel_address,
	output logic [cpre_pkg::COLOR_BITS-1:0] pixel_color,
	output logic                            last_pixel,
	output logic                            busy_res
);
	import cpre_pkg::*;

	logic [2*SCR_BITS-1:0] prod;
	logic [2*SCR_BITS-1:0] lin;

	assign pop = head_valid && (!out_valid || out_ready);
	assign prod = head.py * head.stride;
	assign lin = prod + (2*SCR_BITS)'(head.px);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (pop)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			write_enable <= head.we;
			pixel_address <= head.mul ? lin[ADDR_BITS-1:0] : head.caddr;
			pixel_color <= head.color;
			last_pixel <= head.last;
			busy_res <= head.busy;
		end
	end

endmodule

// ----- src/clipped_pixel_raster_engine_unit.sv -----
// Pixel raster engine: takes clear, plot, line, rectangle-outline and filled-rectangle
// commands and answers every input beat with one result beat. A command beat latches
// its operands (aborting any drawing in flight) and returns no write; each tick beat
// after it yields the next pixel, clipped to the screen, at address y*width+x. Items
// are accepted one per clock while in_ready is high. The front forms the result as
// the beat is taken and parks it in a four-entry queue; the back registers it with
// the address multiply. While out_ready is low the queue and the output register
// absorb five beats before in_ready drops. Width and height writes on the cfg
// channel are always taken and apply from the next accepted input beat; beats
// already taken keep the geometry they saw.
module clipped_pixel_raster_engine_unit #(
	parameter int MAX_SCREEN_WIDTH = 1024,
	parameter int MAX_SCREEN_HEIGHT = 1024,
	parameter int COORD_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [2:0]                          op,
	input  logic signed [COORD_BITS-1:0]        pos_x,
	input  logic signed [COORD_BITS-1:0]        pos_y,
	input  logic signed [COORD_BITS-1:0]        to_x,
	input  logic signed [COORD_BITS-1:0]        to_y,
	input  logic signed [COORD_BITS-1:0]        rect_width,
	input  logic signed [COORD_BITS-1:0]        rect_height,
	input  logic [cpre_pkg::COLOR_BITS-1:0]     color,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                write_enable,
	output logic [cpre_pkg::ADDR_BITS-1:0]      pixel_address,
	output logic [cpre_pkg::COLOR_BITS-1:0]     pixel_color,
	output logic                                last_pixel,
	output logic                                busy_res,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [cpre_pkg::SCR_BITS-1:0]       cfg_data
);
	import cpre_pkg::*;

	logic [SCR_BITS-1:0] scr_w_q, scr_h_q;
	geom_t geom;
	logic [2*SCR_BITS-1:0] area;
	logic push, full, pop, head_valid;
	pix_rec_t wr_rec, head;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= SCR_BITS'(320);
			scr_h_q <= SCR_BITS'(200);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WIDTH: scr_w_q <= cfg_data;
				CFG_HEIGHT: scr_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturate to the supported screen and derive the clear length
	always_comb begin
		geom.w = (int'(scr_w_q) > MAX_SCREEN_WIDTH) ? SCR_BITS'(MAX_SCREEN_WIDTH) : scr_w_q;
		geom.h = (int'(scr_h_q) > MAX_SCREEN_HEIGHT) ? SCR_BITS'(MAX_SCREEN_HEIGHT) : scr_h_q;
		area = geom.w * geom.h;
		geom.clen = (area > (2*SCR_BITS)'(CLEAR_CAP)) ? (ADDR_BITS+1)'(CLEAR_CAP)
			: area[ADDR_BITS:0];
	end

	cpre_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .pos_x(pos_x), .pos_y(pos_y), .to_x(to_x), .to_y(to_y),
		.rect_width(rect_width), .rect_height(rect_height), .color(color),
		.geom(geom), .push(push), .rec(wr_rec), .full(full)
	);

	cpre_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wr_rec(wr_rec), .full(full),
		.pop(pop), .not_empty(head_valid), .rd_rec(head)
	);

	cpre_back u_back (
		.clk(clk), .arst_n(arst_n),
		.head_valid(head_valid), .head(head), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.write_enable(write_enable), .pixel_address(pixel_address),
		.pixel_color(pixel_color), .last_pixel(last_pixel), .busy_res(busy_res)
	);

endmodule
